/* rtl/core/srfp_pkg.sv */
// Shared types and constants for the serial reply frame parser.
package srfp_pkg;

  localparam logic [7:0] CH_REPLY = 8'h26;  // '&'
  localparam logic [7:0] CH_DEVERR = 8'h21; // '!'
  localparam logic [7:0] CH_SHORT = 8'h2A;  // '*'
  localparam logic [7:0] CH_LONG = 8'h23;   // '#'
  localparam logic [7:0] CH_END = 8'h24;    // '$'

  localparam logic [2:0] KIND_REPLY = 3'd0;
  localparam logic [2:0] KIND_SHORT = 3'd1;
  localparam logic [2:0] KIND_LONG_END = 3'd2;
  localparam logic [2:0] KIND_PAYLOAD = 3'd3;
  localparam logic [2:0] KIND_ERROR = 3'd4;

  localparam logic [2:0] ERR_NONE = 3'd0;
  localparam logic [2:0] ERR_BAD_START = 3'd1;
  localparam logic [2:0] ERR_BAD_END = 3'd2;
  localparam logic [2:0] ERR_BAD_TRAP = 3'd3;
  localparam logic [2:0] ERR_TIMEOUT = 3'd4;

  localparam logic CFG_TRAP_LIMIT = 1'b0;
  localparam logic CFG_TIMEOUT_TICKS = 1'b1;

  localparam logic [7:0] TRAP_LIMIT_RESET = 8'd10;
  localparam logic [23:0] TIMEOUT_TICKS_RESET = 24'd5000;

  typedef struct packed {
    logic [2:0]  result_kind;
    logic [3:0]  op_code;
    logic [3:0]  data_type;
    logic [7:0]  variable;
    logic [15:0] value;
    logic [7:0]  device_error;
    logic [7:0]  trap_number;
    logic [7:0]  payload_byte;
    logic [2:0]  error_code;
  } result_t;

endpackage

/* rtl/core/serial_reply_frame_parser_core.sv */
// Top level of the serial reply frame parser: input register, config, parser, result register.
// A request waits in the input register; its result, if any, then loads the output register.
// Throughput: one request per cycle while the output does not stall; the parser state update
// is a single pass between the input register and the result register.
// A stalled output holds the input register, which then stalls the input.
// Synchronous active-high reset: idle parser, cleared held fields, config to defaults.
module serial_reply_frame_parser_core
  import srfp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        mode,
  input  logic [7:0]  rx_byte,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [23:0] cfg_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  result_kind,
  output logic [3:0]  op_code,
  output logic [3:0]  data_type,
  output logic [7:0]  variable,
  output logic [15:0] value,
  output logic [7:0]  device_error,
  output logic [7:0]  trap_number,
  output logic [7:0]  payload_byte,
  output logic [2:0]  error_code
);

  logic        s1_valid;
  logic        s1_mode;
  logic [7:0]  s1_byte;
  logic        advance;
  logic        fire;
  logic        in_take;
  logic [7:0]  trap_limit;
  logic [23:0] timeout_ticks;
  logic        res_valid;
  result_t     res;

  assign cfg_ready = 1'b1;
  assign advance = !out_valid || !out_stall;
  assign fire = s1_valid && advance;
  assign in_stall = s1_valid && !advance;
  assign in_take = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      trap_limit <= TRAP_LIMIT_RESET;
      timeout_ticks <= TIMEOUT_TICKS_RESET;
    end else begin
      if (in_take) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_TRAP_LIMIT: trap_limit <= cfg_data[7:0];
          CFG_TIMEOUT_TICKS: timeout_ticks <= cfg_data;
          default: ;
        endcase
      end
    end
    if (in_take) begin
      s1_mode <= mode;
      s1_byte <= rx_byte;
    end
  end

  srfp_parse u_parse (
    .clk(clk),
    .rst(rst),
    .fire(fire),
    .mode(s1_mode),
    .rx_byte(s1_byte),
    .trap_limit(trap_limit),
    .timeout_ticks(timeout_ticks),
    .res_valid(res_valid),
    .res(res)
  );

  srfp_out u_out (
    .clk(clk),
    .rst(rst),
    .load(fire && res_valid),
    .res(res),
    .out_stall(out_stall),
    .out_valid(out_valid),
    .result_kind(result_kind),
    .op_code(op_code),
    .data_type(data_type),
    .variable(variable),
    .value(value),
    .device_error(device_error),
    .trap_number(trap_number),
    .payload_byte(payload_byte),
    .error_code(error_code)
  );

`ifndef SYNTHESIS
  a_stall_has_item: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid && out_valid)
    else $error("input stalled without a pending request");
  a_result_lands: assert property (@(posedge clk) disable iff (rst)
    fire && res_valid |=> out_valid)
    else $error("result lost on the way to the output register");
  a_payload_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind != KIND_PAYLOAD |-> payload_byte == 8'd0)
    else $error("payload byte outside a payload result");
`endif

endmodule

/* rtl/core/srfp_parse.sv */
// Frame parser state and per-request decode logic.
module srfp_parse
  import srfp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        fire,
  input  logic        mode,
  input  logic [7:0]  rx_byte,
  input  logic [7:0]  trap_limit,
  input  logic [23:0] timeout_ticks,
  output logic        res_valid,
  output result_t     res
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_OPTYPE, ST_VAR, ST_VALHI, ST_VALLO, ST_END_REPLY,
    ST_ERRBYTE, ST_END_ERR, ST_SHORTNUM, ST_END_SHORT, ST_LONGNUM,
    ST_LONGLEN, ST_PAYLOAD, ST_END_LONG
  } step_t;

  step_t       step, step_next;
  logic [3:0]  held_op, held_op_next;
  logic [3:0]  held_type, held_type_next;
  logic [7:0]  held_variable, held_variable_next;
  logic [15:0] held_value, held_value_next;
  logic [7:0]  frame_error_byte, frame_error_byte_next;
  logic [7:0]  frame_trap, frame_trap_next;
  logic [7:0]  payload_left, payload_left_next;
  logic [23:0] idle_count, idle_count_next;
  logic [23:0] count_inc;
  logic [7:0]  left_dec;
  logic [2:0]  kind;
  logic [7:0]  dev, trap, pay;
  logic [2:0]  err;

  assign count_inc = idle_count + 24'd1;
  assign left_dec = payload_left - 8'd1;

  always_comb begin
    step_next = step;
    held_op_next = held_op;
    held_type_next = held_type;
    held_variable_next = held_variable;
    held_value_next = held_value;
    frame_error_byte_next = frame_error_byte;
    frame_trap_next = frame_trap;
    payload_left_next = payload_left;
    idle_count_next = 24'd0;
    res_valid = 1'b0;
    kind = KIND_REPLY;
    dev = 8'd0;
    trap = 8'd0;
    pay = 8'd0;
    err = ERR_NONE;
    if (mode) begin
      if (step != ST_IDLE) begin
        idle_count_next = count_inc;
        if (count_inc >= timeout_ticks) begin
          step_next = ST_IDLE;
          idle_count_next = 24'd0;
          res_valid = 1'b1;
          kind = KIND_ERROR;
          err = ERR_TIMEOUT;
        end
      end
    end else begin
      unique case (step)
        ST_IDLE: begin
          frame_error_byte_next = 8'd0;
          frame_trap_next = 8'd0;
          payload_left_next = 8'd0;
          case (rx_byte)
            CH_REPLY: step_next = ST_OPTYPE;
            CH_DEVERR: step_next = ST_ERRBYTE;
            CH_SHORT: step_next = ST_SHORTNUM;
            CH_LONG: step_next = ST_LONGNUM;
            default: begin
              res_valid = 1'b1;
              kind = KIND_ERROR;
              err = ERR_BAD_START;
            end
          endcase
        end
        ST_OPTYPE: begin
          held_op_next = rx_byte[7:4];
          held_type_next = rx_byte[3:0];
          step_next = ST_VAR;
        end
        ST_VAR: begin
          held_variable_next = rx_byte;
          step_next = ST_VALHI;
        end
        ST_VALHI: begin
          held_value_next = {rx_byte, 8'd0};
          step_next = ST_VALLO;
        end
        ST_VALLO: begin
          held_value_next = {held_value[15:8], rx_byte};
          step_next = ST_END_REPLY;
        end
        ST_ERRBYTE: begin
          frame_error_byte_next = rx_byte;
          step_next = ST_END_ERR;
        end
        ST_SHORTNUM: begin
          frame_trap_next = rx_byte;
          step_next = ST_END_SHORT;
        end
        ST_LONGNUM: begin
          frame_trap_next = rx_byte;
          step_next = ST_LONGLEN;
        end
        ST_LONGLEN: begin
          payload_left_next = rx_byte;
          step_next = (rx_byte == 8'd0) ? ST_END_LONG : ST_PAYLOAD;
        end
        ST_PAYLOAD: begin
          payload_left_next = left_dec;
          if (left_dec == 8'd0) step_next = ST_END_LONG;
          res_valid = 1'b1;
          kind = KIND_PAYLOAD;
          trap = frame_trap;
          pay = rx_byte;
        end
        ST_END_REPLY, ST_END_ERR, ST_END_SHORT, ST_END_LONG: begin
          step_next = ST_IDLE;
          res_valid = 1'b1;
          if (rx_byte != CH_END) begin
            kind = KIND_ERROR;
            err = ERR_BAD_END;
          end else if (step == ST_END_SHORT) begin
            trap = frame_trap;
            if (frame_trap == 8'd0 || frame_trap > trap_limit) begin
              kind = KIND_ERROR;
              err = ERR_BAD_TRAP;
            end else begin
              kind = KIND_SHORT;
            end
          end else if (step == ST_END_LONG) begin
            kind = KIND_LONG_END;
            trap = frame_trap;
          end else if (step == ST_END_ERR) begin
            dev = frame_error_byte;
          end
        end
        default: step_next = ST_IDLE;
      endcase
    end
  end

  always_comb begin
    res.result_kind = kind;
    res.op_code = (kind == KIND_REPLY) ? held_op : 4'd0;
    res.data_type = (kind == KIND_REPLY) ? held_type : 4'd0;
    res.variable = (kind == KIND_REPLY) ? held_variable : 8'd0;
    res.value = (kind == KIND_REPLY) ? held_value : 16'd0;
    res.device_error = dev;
    res.trap_number = trap;
    res.payload_byte = pay;
    res.error_code = err;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= ST_IDLE;
      held_op <= 4'd0;
      held_type <= 4'd0;
      held_variable <= 8'd0;
      held_value <= 16'd0;
      frame_error_byte <= 8'd0;
      frame_trap <= 8'd0;
      payload_left <= 8'd0;
      idle_count <= 24'd0;
    end else if (fire) begin
      step <= step_next;
      held_op <= held_op_next;
      held_type <= held_type_next;
      held_variable <= held_variable_next;
      held_value <= held_value_next;
      frame_error_byte <= frame_error_byte_next;
      frame_trap <= frame_trap_next;
      payload_left <= payload_left_next;
      idle_count <= idle_count_next;
    end
  end

`ifndef SYNTHESIS
  a_idle_no_count: assert property (@(posedge clk) disable iff (rst)
    step == ST_IDLE |-> idle_count == 24'd0)
    else $error("idle count nonzero while idle");
  a_payload_left: assert property (@(posedge clk) disable iff (rst)
    step == ST_PAYLOAD |-> payload_left != 8'd0)
    else $error("payload state with nothing left");
  a_kind_err: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> ((res.result_kind == KIND_ERROR) == (res.error_code != ERR_NONE)))
    else $error("error code and kind disagree");
`endif

endmodule

/* rtl/core/srfp_out.sv */
// Result register for the output channel.
module srfp_out
  import srfp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  result_t     res,
  input  logic        out_stall,
  output logic        out_valid,
  output logic [2:0]  result_kind,
  output logic [3:0]  op_code,
  output logic [3:0]  data_type,
  output logic [7:0]  variable,
  output logic [15:0] value,
  output logic [7:0]  device_error,
  output logic [7:0]  trap_number,
  output logic [7:0]  payload_byte,
  output logic [2:0]  error_code
);

  result_t held;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (load) held <= res;
  end

  assign result_kind = held.result_kind;
  assign op_code = held.op_code;
  assign data_type = held.data_type;
  assign variable = held.variable;
  assign value = held.value;
  assign device_error = held.device_error;
  assign trap_number = held.trap_number;
  assign payload_byte = held.payload_byte;
  assign error_code = held.error_code;

endmodule

/* verif/testbench.sv */
// Testbench for the serial reply frame parser core: scoreboard-checked random and directed frames.
`timescale 1ns / 100ps

module testbench;
  import srfp_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_ITEMS = 175;
  localparam logic [8:0] TICK = 9'h100;
  localparam logic [8:0] S_REPLY = {1'b0, CH_REPLY};
  localparam logic [8:0] S_DEVERR = {1'b0, CH_DEVERR};
  localparam logic [8:0] S_SHORT = {1'b0, CH_SHORT};
  localparam logic [8:0] S_LONG = {1'b0, CH_LONG};
  localparam logic [8:0] S_END = {1'b0, CH_END};

  typedef enum logic [3:0] {
    P_IDLE, P_OPTYPE, P_VAR, P_VALHI, P_VALLO, P_END_REPLY, P_ERRBYTE, P_END_ERR,
    P_SHORTNUM, P_END_SHORT, P_LONGNUM, P_LONGLEN, P_PAYLOAD, P_END_LONG
  } parse_step_e;

  class frame_scoreboard;
    logic [7:0]  trap_limit;
    logic [23:0] timeout_ticks;
    parse_step_e step;
    logic [3:0]  held_op;
    logic [3:0]  held_type;
    logic [7:0]  held_var;
    logic [15:0] held_value;
    logic [7:0]  frame_err;
    logic [7:0]  frame_trap;
    logic [7:0]  payload_left;
    logic [23:0] idle_count;
    result_t     expected_q[$];
    int          mismatches;
    int          requests;
    int          results;
    int          kind_count[5];

    function new();
      trap_limit = TRAP_LIMIT_RESET;
      timeout_ticks = TIMEOUT_TICKS_RESET;
      step = P_IDLE;
      held_op = '0;
      held_type = '0;
      held_var = '0;
      held_value = '0;
      frame_err = '0;
      frame_trap = '0;
      payload_left = '0;
      idle_count = '0;
    endfunction

    function void write_reg(logic idx, logic [23:0] d);
      if (idx == CFG_TRAP_LIMIT) trap_limit = d[7:0];
      else timeout_ticks = d;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_request(logic m, logic [7:0] c);
      result_t r;
      bit      hit;
      r = '0;
      hit = 0;
      requests++;
      if (m) begin
        if (step == P_IDLE) begin
          idle_count = '0;
        end else begin
          idle_count = idle_count + 24'd1;
          if (idle_count >= timeout_ticks) begin
            step = P_IDLE;
            idle_count = '0;
            r.result_kind = KIND_ERROR;
            r.error_code = ERR_TIMEOUT;
            hit = 1;
          end
        end
      end else begin
        idle_count = '0;
        case (step)
          P_IDLE: begin
            frame_err = '0;
            frame_trap = '0;
            payload_left = '0;
            if (c == CH_REPLY) step = P_OPTYPE;
            else if (c == CH_DEVERR) step = P_ERRBYTE;
            else if (c == CH_SHORT) step = P_SHORTNUM;
            else if (c == CH_LONG) step = P_LONGNUM;
            else begin
              r.result_kind = KIND_ERROR;
              r.error_code = ERR_BAD_START;
              hit = 1;
            end
          end
          P_OPTYPE: begin
            held_op = c[7:4];
            held_type = c[3:0];
            step = P_VAR;
          end
          P_VAR: begin
            held_var = c;
            step = P_VALHI;
          end
          P_VALHI: begin
            held_value = {c, 8'h00};
            step = P_VALLO;
          end
          P_VALLO: begin
            held_value = held_value + {8'h00, c};
            step = P_END_REPLY;
          end
          P_ERRBYTE: begin
            frame_err = c;
            step = P_END_ERR;
          end
          P_SHORTNUM: begin
            frame_trap = c;
            step = P_END_SHORT;
          end
          P_LONGNUM: begin
            frame_trap = c;
            step = P_LONGLEN;
          end
          P_LONGLEN: begin
            payload_left = c;
            step = (c == 8'd0) ? P_END_LONG : P_PAYLOAD;
          end
          P_PAYLOAD: begin
            payload_left = payload_left - 8'd1;
            if (payload_left == 8'd0) step = P_END_LONG;
            r.result_kind = KIND_PAYLOAD;
            r.trap_number = frame_trap;
            r.payload_byte = c;
            hit = 1;
          end
          default: begin
            hit = 1;
            if (c != CH_END) begin
              r.result_kind = KIND_ERROR;
              r.error_code = ERR_BAD_END;
            end else if (step == P_END_SHORT) begin
              if (frame_trap == 8'd0 || frame_trap > trap_limit) begin
                r.result_kind = KIND_ERROR;
                r.error_code = ERR_BAD_TRAP;
              end else begin
                r.result_kind = KIND_SHORT;
              end
              r.trap_number = frame_trap;
            end else if (step == P_END_LONG) begin
              r.result_kind = KIND_LONG_END;
              r.trap_number = frame_trap;
            end else begin
              r.result_kind = KIND_REPLY;
              r.op_code = held_op;
              r.data_type = held_type;
              r.variable = held_var;
              r.value = held_value;
              r.device_error = (step == P_END_ERR) ? frame_err : 8'h00;
            end
            step = P_IDLE;
          end
        endcase
      end
      if (hit) expected_q.push_back(r);
    endfunction

    function void check_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        $error("result with nothing pending: kind %0h", got.result_kind);
        mismatches++;
        return;
      end
      want = expected_q.pop_front();
      results++;
      if (want.result_kind <= KIND_ERROR) kind_count[want.result_kind]++;
      check_field("result_kind", 16'(want.result_kind), 16'(got.result_kind));
      check_field("op_code", 16'(want.op_code), 16'(got.op_code));
      check_field("data_type", 16'(want.data_type), 16'(got.data_type));
      check_field("variable", 16'(want.variable), 16'(got.variable));
      check_field("value", want.value, got.value);
      check_field("device_error", 16'(want.device_error), 16'(got.device_error));
      check_field("trap_number", 16'(want.trap_number), 16'(got.trap_number));
      check_field("payload_byte", 16'(want.payload_byte), 16'(got.payload_byte));
      check_field("error_code", 16'(want.error_code), 16'(got.error_code));
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic        mode;
  logic [7:0]  rx_byte;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [23:0] cfg_data;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  result_kind;
  logic [3:0]  op_code;
  logic [3:0]  data_type;
  logic [7:0]  variable;
  logic [15:0] value;
  logic [7:0]  device_error;
  logic [7:0]  trap_number;
  logic [7:0]  payload_byte;
  logic [2:0]  error_code;

  frame_scoreboard sb;
  int cycle_count = 0;
  int items_sent = 0;
  bit calm = 0;
  bit hold_req = 0;
  logic [8:0] directed_q[$];

  serial_reply_frame_parser_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .mode(mode), .rx_byte(rx_byte),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .out_valid(out_valid), .out_stall(out_stall),
    .result_kind(result_kind), .op_code(op_code), .data_type(data_type), .variable(variable),
    .value(value), .device_error(device_error), .trap_number(trap_number),
    .payload_byte(payload_byte), .error_code(error_code)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("testbench failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) sb.note_request(mode, rx_byte);
      if (out_valid && !out_stall)
        sb.check_result({result_kind, op_code, data_type, variable, value, device_error,
                         trap_number, payload_byte, error_code});
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 0;
      end else begin
        out_stall <= !calm && ($urandom_range(0, 99) < 24);
      end
    end
  end

  task automatic send_item(logic m, logic [7:0] b);
    if (!calm && $urandom_range(0, 99) < 16) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= m;
    rx_byte <= b;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  task automatic write_reg(logic idx, logic [23:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, d);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic finish_phase();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [7:0] rand_byte();
    int p;
    p = $urandom_range(0, 9);
    if (p == 0) return 8'h00;
    if (p == 1) return 8'hFF;
    return 8'($urandom);
  endfunction

  function automatic logic [7:0] end_byte();
    logic [7:0] b;
    if ($urandom_range(0, 9) != 0) return CH_END;
    b = 8'($urandom);
    if (b == CH_END) b = b + 8'd1;
    return b;
  endfunction

  function automatic logic [7:0] start_mark();
    case ($urandom_range(0, 3))
      0: return CH_REPLY;
      1: return CH_DEVERR;
      2: return CH_SHORT;
      default: return CH_LONG;
    endcase
  endfunction

  // byte inside a frame, now and then preceded by a tick
  task automatic frame_byte(logic [7:0] b);
    if ($urandom_range(0, 99) < 5) send_item(1'b1, 8'($urandom));
    send_item(1'b0, b);
  endtask

  task automatic send_long(logic [7:0] num, int len);
    send_item(1'b0, CH_LONG);
    frame_byte(num);
    frame_byte(8'(len));
    repeat (len) frame_byte(($urandom_range(0, 99) < 15) ? CH_END : rand_byte());
    frame_byte(end_byte());
  endtask

  task automatic random_frame();
    int         pick;
    int         len;
    logic [7:0] num;
    pick = $urandom_range(0, 99);
    if (pick < 22) begin
      send_item(1'b0, CH_REPLY);
      repeat (4) frame_byte(rand_byte());
      frame_byte(end_byte());
    end else if (pick < 34) begin
      send_item(1'b0, CH_DEVERR);
      frame_byte(rand_byte());
      frame_byte(end_byte());
    end else if (pick < 52) begin
      case ($urandom_range(0, 4))
        0: num = 8'd0;
        1: num = sb.trap_limit;
        2: num = sb.trap_limit + 8'd1;
        default: num = 8'($urandom);
      endcase
      send_item(1'b0, CH_SHORT);
      frame_byte(num);
      frame_byte(end_byte());
    end else if (pick < 72) begin
      len = ($urandom_range(0, 99) < 3) ? $urandom_range(30, 255) : $urandom_range(0, 6);
      send_long(rand_byte(), len);
    end else if (pick < 82) begin
      if ($urandom_range(0, 99) < 30) send_item(1'b1, 8'($urandom));
      else send_item(1'b0, rand_byte());
    end else begin
      // frame cut short, then ticks toward the timeout
      send_item(1'b0, start_mark());
      repeat ($urandom_range(0, 3)) send_item(1'b0, rand_byte());
      len = (sb.timeout_ticks <= 24'd64) ? int'(sb.timeout_ticks) : $urandom_range(1, 4);
      repeat (len) send_item(1'b1, 8'($urandom));
    end
  endtask

  initial begin
    int          p;
    int          target;
    logic [7:0]  lim;
    logic [23:0] tmo;
    sb = new();
    rst <= 1'b1;
    in_valid <= 1'b0;
    mode <= 1'b0;
    rx_byte <= 8'h00;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_TRAP_LIMIT;
    cfg_data <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_reg(CFG_TIMEOUT_TICKS, 24'd2);
    directed_q = {
      TICK,
      S_REPLY, 9'h0F0, 9'h0FF, 9'h0FF, 9'h000, S_END,
      S_DEVERR, 9'h000, S_END,
      S_LONG, 9'h024, 9'h002, 9'h024, 9'h05A, S_END,
      S_LONG, 9'h0FF, 9'h000, 9'h041,
      S_SHORT, 9'h000, S_END,
      9'h041,
      S_REPLY, 9'h00F, TICK, TICK
    };
    foreach (directed_q[i]) send_item(directed_q[i][8], directed_q[i][7:0]);

    for (p = 0; p < 6; p++) begin
      finish_phase();
      lim = 8'($urandom_range(1, 255));
      case (p)
        0: begin lim = 8'd255; tmo = 24'd1; end
        1: begin lim = 8'd1; tmo = 24'hFFFFFF; end
        2: tmo = 24'($urandom_range(2, 40));
        3: begin lim = TRAP_LIMIT_RESET; tmo = 24'($urandom_range(3, 12)); end
        4: tmo = 24'($urandom_range(1, 24'hFFFFFF));
        default: tmo = 24'($urandom_range(1, 30));
      endcase
      write_reg(CFG_TRAP_LIMIT, {16'h0000, lim});
      write_reg(CFG_TIMEOUT_TICKS, tmo);
      calm = (p == 1);
      target = items_sent + PHASE_ITEMS;
      if (p == 2) begin
        hold_req = 1;
        send_long(8'h77, 60);
      end
      while (items_sent < target) random_frame();
      calm = 0;
    end
    finish_phase();
    repeat (10) @(posedge clk);

    $display("run: %0d requests over 7 register settings, %0d results checked",
             sb.requests, sb.results);
    $display("  replies %0d, short traps %0d, long trap ends %0d, payload %0d, errors %0d",
             sb.kind_count[KIND_REPLY], sb.kind_count[KIND_SHORT],
             sb.kind_count[KIND_LONG_END], sb.kind_count[KIND_PAYLOAD],
             sb.kind_count[KIND_ERROR]);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/srfp_pkg.sv
rtl/core/srfp_parse.sv
rtl/core/srfp_out.sv
rtl/core/serial_reply_frame_parser_core.sv
verif/testbench.sv
